/* rtl/pds_pkg.sv */
package pds_pkg;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_W    = 3;
	localparam int ADDR_W     = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
	localparam int TICK_W     = 64;
	localparam int CNT_W      = 32;
	localparam int ENTRY_W    = 3 * TICK_W + CNT_W;

	localparam logic [31:0] TPM_RESET = 32'd1000000;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic load;
		logic apply;
		logic rd_en;
		logic rd_open;
		logic wr_en;
		logic cap;
		logic avg_go;
		logic done;
	} pds_cmd_t;

	typedef struct packed {
		logic end_upd;
		logic div_done;
	} pds_stat_t;

endpackage

/* rtl/pds_ram.sv */
module pds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pds_div.sv */
module pds_div
	import pds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [TICK_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic [TICK_W-1:0] quotient,
	output logic              done
);

	logic [CNT_W:0]                rem_q;
	logic [TICK_W-1:0]             quo_q;
	logic [CNT_W-1:0]              dvs_q;
	logic [$clog2(TICK_W)-1:0]     step_q;
	logic                          run_q;
	logic                          done_q;
	logic [CNT_W:0]                shifted;
	logic                          fits;
	logic [CNT_W:0]                rem_next;

	assign shifted  = {rem_q[CNT_W-1:0], quo_q[TICK_W-1]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign rem_next = fits ? (shifted - {1'b0, dvs_q}) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == '1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[TICK_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("divider done without a running division");

endmodule

/* rtl/pds_datapath.sv */
module pds_datapath
	import pds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  pds_cmd_t           cmd,
	output pds_stat_t          stat,
	input  logic [1:0]         command,
	input  logic [PHASE_W-1:0] phase,
	input  logic [TICK_W-1:0]  timestamp,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic [TICK_W-1:0]  min_ms,
	output logic [TICK_W-1:0]  max_ms,
	output logic [TICK_W-1:0]  total_ms,
	output logic [TICK_W-1:0]  average_ms,
	output logic [CNT_W-1:0]   sample_count,
	output logic               no_open_phase
);

	logic [31:0]           tpm_q;
	logic [1:0]            cmd_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [TICK_W-1:0]     ts_q;
	logic                  open_vld_q;
	logic [ADDR_W-1:0]     open_idx_q;
	logic [TICK_W-1:0]     start_q;
	logic                  flag_q;
	logic [NUM_PHASES-1:0] vld_q;
	logic                  rd_vld_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TICK_W-1:0]     min_res_q;
	logic                  strobe_q;
	logic [TICK_W-1:0]     min_out_q;
	logic [TICK_W-1:0]     max_out_q;
	logic [TICK_W-1:0]     tot_out_q;
	logic [TICK_W-1:0]     avg_out_q;
	logic [CNT_W-1:0]      cnt_out_q;
	logic                  flag_out_q;

	logic [PHASE_W:0]      phase_x;
	logic                  phase_ok;
	logic [ADDR_W-1:0]     phase_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]    rdata;
	logic [ENTRY_W-1:0]    ent;
	logic [TICK_W-1:0]     e_min, e_max, e_sum;
	logic [CNT_W-1:0]      e_cnt;
	logic [TICK_W-1:0]     dt;
	logic                  first;
	logic [TICK_W-1:0]     n_min, n_max, n_sum;
	logic [TICK_W:0]       sum_wide;
	logic [CNT_W-1:0]      n_cnt;
	logic [ENTRY_W-1:0]    wdata;
	logic [31:0]           dvs;
	logic [TICK_W-1:0]     rep_min, rep_max, rep_sum;
	logic [CNT_W-1:0]      rep_cnt;
	logic                  rep_ok;
	logic                  div0_go;
	logic [TICK_W-1:0]     div0_dividend;
	logic [CNT_W-1:0]      div0_divisor;
	logic [TICK_W-1:0]     q0, q1, q2;
	logic                  d0, d1, d2;

	assign phase_x    = {1'b0, phase_q};
	assign phase_ok   = phase_x < (PHASE_W + 1)'(NUM_PHASES);
	assign phase_addr = phase_x[ADDR_W-1:0];
	assign rd_addr    = cmd.rd_open ? open_idx_q : phase_addr;

	assign stat.end_upd  = (cmd_q == CMD_END) && open_vld_q;
	assign stat.div_done = d0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q      <= TPM_RESET;
			open_vld_q <= 1'b0;
			open_idx_q <= '0;
			start_q    <= '0;
			vld_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.done;
			if (cfg_we) begin
				tpm_q <= cfg_wdata;
			end
			if (cmd.apply && (cmd_q == CMD_START) && phase_ok) begin
				open_vld_q <= 1'b1;
				open_idx_q <= phase_addr;
				start_q    <= ts_q;
			end
			if (cmd.wr_en) begin
				open_vld_q        <= 1'b0;
				vld_q[open_idx_q] <= 1'b1;
			end
		end
	end

	// request capture and per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			phase_q <= phase;
			ts_q    <= timestamp;
			flag_q  <= 1'b0;
		end
		if (cmd.apply && (cmd_q == CMD_END) && !open_vld_q) begin
			flag_q <= 1'b1;
		end
		if (cmd.rd_en) begin
			rd_vld_q <= vld_q[rd_addr];
		end
		if (cmd.cap) begin
			cnt_q <= rep_cnt;
		end
		if (cmd.avg_go) begin
			min_res_q <= q0;
		end
		if (cmd.done) begin
			min_out_q  <= min_res_q;
			max_out_q  <= q1;
			tot_out_q  <= q2;
			avg_out_q  <= (cnt_q == '0) ? '0 : q0;
			cnt_out_q  <= cnt_q;
			flag_out_q <= flag_q;
		end
	end

	pds_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_PHASES)
	) u_stats (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(open_idx_q),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// entries never written read as zero
	assign ent = rd_vld_q ? rdata : '0;
	assign {e_min, e_max, e_sum, e_cnt} = ent;

	assign dt       = ts_q - start_q;
	assign first    = (e_cnt == '0);
	assign n_min    = (first || (dt < e_min)) ? dt : e_min;
	assign n_max    = (first || (dt > e_max)) ? dt : e_max;
	assign sum_wide = {1'b0, e_sum} + {1'b0, dt};
	assign n_sum    = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
	assign n_cnt    = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;
	assign wdata    = {n_min, n_max, n_sum, n_cnt};

	assign rep_ok  = phase_ok;
	assign rep_min = rep_ok ? e_min : '0;
	assign rep_max = rep_ok ? e_max : '0;
	assign rep_sum = rep_ok ? e_sum : '0;
	assign rep_cnt = rep_ok ? e_cnt : '0;

	assign dvs = (tpm_q == '0) ? 32'd1 : tpm_q;

	// unit 0 converts the minimum, then forms the average
	assign div0_go       = cmd.cap || cmd.avg_go;
	assign div0_dividend = cmd.avg_go ? q2 : rep_min;
	assign div0_divisor  = cmd.avg_go ? cnt_q : dvs;

	pds_div u_div0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div0_go),
		.dividend(div0_dividend),
		.divisor (div0_divisor),
		.quotient(q0),
		.done    (d0)
	);

	pds_div u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.cap),
		.dividend(rep_max),
		.divisor (dvs),
		.quotient(q1),
		.done    (d1)
	);

	pds_div u_div2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.cap),
		.dividend(rep_sum),
		.divisor (dvs),
		.quotient(q2),
		.done    (d2)
	);

	assign done          = strobe_q;
	assign min_ms        = min_out_q;
	assign max_ms        = max_out_q;
	assign total_ms      = tot_out_q;
	assign average_ms    = avg_out_q;
	assign sample_count  = cnt_out_q;
	assign no_open_phase = flag_out_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |=> !strobe_q)
		else $error("result strobe longer than one cycle");

	a_write_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> open_vld_q)
		else $error("statistics written with no open phase");

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		d1 |-> (d0 && d2))
		else $error("conversion units out of step");

endmodule

/* rtl/pds_ctrl.sv */
module pds_ctrl
	import pds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  pds_stat_t stat,
	output pds_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_UPD    = 3'd2;
	localparam logic [2:0] S_RDREP  = 3'd3;
	localparam logic [2:0] S_CAP    = 3'd4;
	localparam logic [2:0] S_CONV   = 3'd5;
	localparam logic [2:0] S_AVG    = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       avg_run_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.apply   = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_open = stat.end_upd;
				state_d     = stat.end_upd ? S_UPD : S_CAP;
			end
			S_UPD: begin
				cmd.wr_en = 1'b1;
				state_d   = S_RDREP;
			end
			S_RDREP: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CAP;
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				state_d = S_CONV;
			end
			S_CONV: begin
				if (stat.div_done) begin
					state_d = avg_run_q ? S_DONE : S_AVG;
				end
			end
			S_AVG: begin
				cmd.avg_go = 1'b1;
				state_d    = S_CONV;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			avg_run_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.cap) begin
				avg_run_q <= 1'b0;
			end else if (cmd.avg_go) begin
				avg_run_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && start |=> (state_q == S_DECODE))
		else $error("request accepted but not decoded");

	a_done_after_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> avg_run_q)
		else $error("result issued before average");

endmodule

/* rtl/phase_duration_statistics.sv */
// Per-phase duration monitor. A request is taken when start is high and busy is low; command
// 0 opens a phase at the given timestamp (dropping any open one), 1 closes the open phase and
// folds the elapsed ticks into its min, max, saturating sum and count, 2 or 3 only reads. Each
// request yields exactly one result, shown for one cycle with done high; the receiver cannot
// stall it, so it must take results as they come. busy stays high from acceptance through the
// statistics read (and, for an end that records a sample, the update and a second read), two
// passes through the bit-serial dividers (first the tick to millisecond conversion, then the
// average) and the result state; done rises in the same cycle that busy falls.
// ticks_per_ms is written through cfg_we/cfg_wdata while idle, which the user must keep to; zero acts as one.
module phase_duration_statistics
	import pds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [PHASE_W-1:0] phase,
	input  logic [TICK_W-1:0]  timestamp,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic [TICK_W-1:0]  min_ms,
	output logic [TICK_W-1:0]  max_ms,
	output logic [TICK_W-1:0]  total_ms,
	output logic [TICK_W-1:0]  average_ms,
	output logic [CNT_W-1:0]   sample_count,
	output logic               no_open_phase
);

	pds_cmd_t  cmd;
	pds_stat_t stat;

	pds_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	pds_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.phase        (phase),
		.timestamp    (timestamp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.min_ms       (min_ms),
		.max_ms       (max_ms),
		.total_ms     (total_ms),
		.average_ms   (average_ms),
		.sample_count (sample_count),
		.no_open_phase(no_open_phase)
	);

endmodule
